// ===== src/lob_pkg.sv =====
// ----------------------------------------------------------------------------
// Order book update package
// Shared widths, codes and payload types of the update unit.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int unsigned PriceLevels = 4096;
  localparam int unsigned OrderSlots  = 64;
  localparam int unsigned PriceW      = $clog2(PriceLevels);
  localparam int unsigned SlotW       = $clog2(OrderSlots);
  localparam int unsigned TotalW      = 48;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REDUCE = 2'd1,
    OP_DELETE = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_PRICE = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] order_key;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } msg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              level_side;
    logic [11:0]       level_price;
    logic [TotalW-1:0] level_total;
    logic [31:0]       remaining_qty;
    logic              order_removed;
  } rsp_t;

endpackage

// ===== src/lob_if.sv =====
// ----------------------------------------------------------------------------
// Order book stream channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lob_msg_if import lob_pkg::*; ();
  logic valid;
  logic ready;
  msg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lob_rsp_if import lob_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/limit_order_book_update_unit.sv =====
// ----------------------------------------------------------------------------
// Limit order book update unit
// Applies add, reduce and delete messages to an order table and level totals.
// Each message passes a slot read and then a level read before its result is
// registered; a new message is taken only after the result is written, and a
// held result beat holds the input.
// Reset: slot valid bits clear at once; level totals clear by a pass over all
// 8192 entries of the level memory during which no message is accepted.
// ----------------------------------------------------------------------------
module limit_order_book_update_unit import lob_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  lob_msg_if.sink   msg_i,
  lob_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_e;

  state_e          state_q;
  logic [PriceW:0] clr_q;
  msg_t            msg_q;
  logic            hit_q;
  logic [SlotW-1:0] slot_q;
  logic            free_q;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic             hit, free;
  logic [SlotW-1:0] hit_slot, free_slot;
  logic             s_side;
  logic [11:0]      s_price;
  logic [31:0]      s_qty;
  logic [TotalW-1:0] lvl_rd;

  logic              lm_rd_en, lm_wr_en;
  logic [PriceW:0]   lm_rd_addr, lm_wr_addr;
  logic [TotalW-1:0] lm_wr_data;
  logic              st_wr_en, st_wr_valid;

  logic [31:0]       take, rem;
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] new_total;
  logic              is_add, is_upd;

  logic accept;
  assign accept = msg_i.valid && msg_i.ready;
  assign msg_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);

  logic price_ok;
  assign price_ok = (msg_q.price != '0) && (msg_q.price < 32'(PriceLevels));

  lob_slot_table u_slots (
    .clk_i, .rst_ni,
    .id_i        (msg_i.data.order_key),
    .hit_o       (hit), .hit_slot_o (hit_slot),
    .free_o      (free), .free_slot_o (free_slot),
    .rd_en_i     (accept),
    .rd_slot_i   (hit_slot),
    .rd_side_o   (s_side), .rd_price_o (s_price), .rd_qty_o (s_qty),
    .wr_en_i     (st_wr_en),
    .wr_slot_i   (slot_q),
    .wr_valid_i  (st_wr_valid),
    .wr_id_i     (msg_q.order_key),
    .wr_side_i   (msg_q.opcode == OP_ADD ? msg_q.side : s_side),
    .wr_price_i  (msg_q.opcode == OP_ADD ? msg_q.price[11:0] : s_price),
    .wr_qty_i    (msg_q.opcode == OP_ADD ? msg_q.quantity : rem)
  );

  lob_level_mem u_levels (
    .clk_i,
    .rd_en_i (lm_rd_en), .rd_addr_i (lm_rd_addr), .rd_data_o (lvl_rd),
    .wr_en_i (lm_wr_en), .wr_addr_i (lm_wr_addr), .wr_data_i (lm_wr_data)
  );

  assign is_add = msg_q.opcode == OP_ADD;
  assign is_upd = msg_q.opcode == OP_REDUCE || msg_q.opcode == OP_DELETE;
  assign take = (msg_q.opcode == OP_REDUCE && msg_q.quantity < s_qty) ?
                msg_q.quantity : s_qty;
  assign rem  = s_qty - take;
  assign sum  = {1'b0, lvl_rd} + (TotalW + 1)'(msg_q.quantity);

  always_comb begin
    if (is_add) new_total = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
    else        new_total = (lvl_rd >= TotalW'(take)) ? lvl_rd - TotalW'(take) : '0;
  end

  logic ok_add, ok_upd;
  assign ok_add = is_add && price_ok && (hit_q || free_q);
  assign ok_upd = is_upd && hit_q;

  always_comb begin
    lm_rd_en = state_q == S_READ;
    lm_rd_addr = is_add ? {msg_q.side, msg_q.price[PriceW-1:0]}
                        : {s_side, s_price[PriceW-1:0]};
    lm_wr_en = 1'b0;
    lm_wr_addr = lm_rd_addr;
    lm_wr_data = new_total;
    if (state_q == S_CLEAR) begin
      lm_wr_en = 1'b1;
      lm_wr_addr = clr_q;
      lm_wr_data = '0;
    end else if (state_q == S_WRITE) begin
      lm_wr_en = ok_add || ok_upd;
    end
    st_wr_en = (state_q == S_WRITE) && (ok_add || ok_upd);
    st_wr_valid = is_add || (rem != '0);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) out_valid_d = 1'b0;
    if (state_q == S_WRITE) out_valid_d = 1'b1;
  end

  always_comb begin
    out_d = out_q;
    if (state_q == S_WRITE) begin
      out_d = '0;
      if (is_add) begin
        if (!price_ok) out_d.status = ST_BAD_PRICE;
        else if (!(hit_q || free_q)) out_d.status = ST_FULL;
        else begin
          out_d.level_side    = msg_q.side;
          out_d.level_price   = msg_q.price[11:0];
          out_d.level_total   = new_total;
          out_d.remaining_qty = msg_q.quantity;
        end
      end else if (is_upd) begin
        if (!hit_q) out_d.status = ST_UNKNOWN;
        else begin
          out_d.level_side    = s_side;
          out_d.level_price   = s_price;
          out_d.level_total   = new_total;
          out_d.remaining_qty = rem;
          out_d.order_removed = rem == '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (PriceW + 1)'(2 * PriceLevels - 1)) state_q <= S_IDLE;
        end
        S_IDLE:  if (accept) state_q <= S_READ;
        S_READ:  state_q <= S_WRITE;
        S_WRITE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      msg_q  <= msg_i.data;
      hit_q  <= hit;
      free_q <= free;
      slot_q <= hit ? hit_slot : free_slot;
    end
    out_q <= out_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ===== src/lob_level_mem.sv =====
// ----------------------------------------------------------------------------
// Level total memory
// Bid and ask totals in one synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lob_level_mem import lob_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [PriceW:0]   rd_addr_i,
  output logic [TotalW-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [PriceW:0]   wr_addr_i,
  input  logic [TotalW-1:0] wr_data_i
);

  logic [TotalW-1:0] mem [2*PriceLevels];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== src/lob_slot_table.sv =====
// ----------------------------------------------------------------------------
// Order slot table
// Valid bits and id match in flops, order fields in a synchronous RAM.
// ----------------------------------------------------------------------------
module lob_slot_table import lob_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      id_i,
  output logic             hit_o,
  output logic [SlotW-1:0] hit_slot_o,
  output logic             free_o,
  output logic [SlotW-1:0] free_slot_o,
  input  logic             rd_en_i,
  input  logic [SlotW-1:0] rd_slot_i,
  output logic             rd_side_o,
  output logic [11:0]      rd_price_o,
  output logic [31:0]      rd_qty_o,
  input  logic             wr_en_i,
  input  logic [SlotW-1:0] wr_slot_i,
  input  logic             wr_valid_i,
  input  logic [63:0]      wr_id_i,
  input  logic             wr_side_i,
  input  logic [11:0]      wr_price_i,
  input  logic [31:0]      wr_qty_i
);

  logic [OrderSlots-1:0] valid_q;
  logic [63:0]           id_q [OrderSlots];
  logic [44:0]           data_mem [OrderSlots];
  logic [44:0]           rd_q;

  always_comb begin
    hit_o = 1'b0;
    hit_slot_o = '0;
    free_o = 1'b0;
    free_slot_o = '0;
    for (int i = OrderSlots - 1; i >= 0; i--) begin
      if (valid_q[i] && id_q[i] == id_i) begin
        hit_o = 1'b1;
        hit_slot_o = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_o = 1'b1;
        free_slot_o = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_slot_i] <= wr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q[wr_slot_i] <= wr_id_i;
      data_mem[wr_slot_i] <= {wr_side_i, wr_price_i, wr_qty_i};
    end
    if (rd_en_i) rd_q <= data_mem[rd_slot_i];
  end

  assign rd_side_o  = rd_q[44];
  assign rd_price_o = rd_q[43:32];
  assign rd_qty_o   = rd_q[31:0];

endmodule
